>>> hw/rtl/sorted_table_binary_search_defines.svh
// assertion macros for the sorted table binary search block
// used by the top level only, no other dependencies
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication under synchronous reset
`define STBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbs: same-cycle implication failed");

// next-cycle implication under synchronous reset
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbs: next-cycle implication failed");

`else

`define STBS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/stbs_pkg.sv
// shared types and constants for the sorted table binary search block
// no dependencies
package stbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;

  // request type codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_SEARCH = 2'b10
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;         // write one table entry
    logic init;         // latch key, set bounds, issue first read
    logic step;         // narrow bounds, issue next read
    logic finish_hit;   // report found at current midpoint
    logic finish_miss;  // report not found
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic init_empty;   // effective length is zero
    logic hit;          // probed entry equals key
    logic next_empty;   // narrowed interval is empty
  } sts_t;

endpackage

>>> hw/rtl/stbs_ctrl.sv
// controller state machine for the sorted table binary search block
// depends on stbs_pkg
module stbs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_req_type,
  input  stbs_pkg::sts_t sts,
  output stbs_pkg::cmd_t cmd,
  output logic           busy
);

  stbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    case (state_r)
      stbs_pkg::ST_IDLE: begin
        if (start) begin
          if (in_req_type == stbs_pkg::REQ_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.init = 1'b1;
            if (sts.init_empty) begin
              cmd.finish_miss = 1'b1;
            end else begin
              state_nxt = stbs_pkg::ST_SEARCH;
            end
          end
        end
      end
      stbs_pkg::ST_SEARCH: begin
        busy = 1'b1;
        if (sts.hit) begin
          cmd.finish_hit = 1'b1;
          state_nxt      = stbs_pkg::ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (sts.next_empty) begin
            cmd.finish_miss = 1'b1;
            state_nxt       = stbs_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = stbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/stbs_dp.sv
// datapath for the sorted table binary search block: table memory,
// bisection bounds, length register and result registers; depends on stbs_pkg
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stbs_pkg::cmd_t                    cmd,
  output stbs_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [stbs_pkg::LEN_W-1:0]        cfg_wdata,
  input  logic [stbs_pkg::IDX_W-1:0]        in_load_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_load_value,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_search_key,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [stbs_pkg::IDX_W-1:0]        out_found_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // signed bound width: holds -1 up to twice the largest length
  localparam int PW = ((AW > 12) ? AW : 12) + 1;

  logic signed [stbs_pkg::KEY_W-1:0] mem [0:TABLE_DEPTH-1];

  logic [stbs_pkg::LEN_W-1:0]        len_r;
  logic signed [stbs_pkg::KEY_W-1:0] key_r;
  logic signed [stbs_pkg::KEY_W-1:0] rdata_r;
  logic signed [PW-1:0]              left_r, right_r, mid_r;
  logic                              out_valid_r, out_found_r;
  logic [stbs_pkg::IDX_W-1:0]        out_index_r;

  logic [31:0]          eff_len;
  logic signed [PW-1:0] eff_pw, init_right, init_mid;
  logic signed [PW-1:0] left_nxt, right_nxt, mid_nxt;
  logic signed [PW-1:0] rd_mid;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 load_ok, rd_en, key_lt;

  // length saturated to the table depth
  always_comb begin
    if ({21'b0, len_r} > 32'(TABLE_DEPTH)) begin
      eff_len = 32'(TABLE_DEPTH);
    end else begin
      eff_len = {21'b0, len_r};
    end
  end

  assign eff_pw     = PW'(eff_len);
  assign init_right = eff_pw - PW'(1);
  assign init_mid   = init_right >>> 1;

  // one bisection step from the registered probe
  assign key_lt = key_r < rdata_r;
  always_comb begin
    if (key_lt) begin
      left_nxt  = left_r;
      right_nxt = mid_r - PW'(1);
    end else begin
      left_nxt  = mid_r + PW'(1);
      right_nxt = right_r;
    end
  end
  assign mid_nxt = (left_nxt + right_nxt) >>> 1;

  assign sts.init_empty = (eff_len == 32'd0);
  assign sts.hit        = (key_r == rdata_r);
  assign sts.next_empty = (left_nxt > right_nxt);

  assign rd_mid  = cmd.init ? init_mid : mid_nxt;
  assign rd_addr = AW'(rd_mid);
  assign rd_en   = cmd.init | cmd.step;
  assign wr_addr = AW'(in_load_index);
  assign load_ok = 32'(in_load_index) < 32'(TABLE_DEPTH);

  // table memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      mem[wr_addr] <= in_load_value;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_we) begin
      len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      key_r   <= in_search_key;
      left_r  <= '0;
      right_r <= init_right;
      mid_r   <= init_mid;
    end else if (cmd.step) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      mid_r   <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish_hit | cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= cmd.finish_hit;
    if (cmd.finish_hit) begin
      out_index_r <= mid_r[stbs_pkg::IDX_W-1:0];
    end else begin
      out_index_r <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_index = out_index_r;

endmodule

>>> hw/rtl/sorted_table_binary_search.sv
// top level of the sorted table binary search block
// depends on stbs_pkg, stbs_ctrl, stbs_dp and sorted_table_binary_search_defines.svh
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+---------------------------
//   input    | in_req_type in_load_index in_load_value      | start high, busy low
//            | in_search_key                                |
//   result   | out_found out_found_index                    | out_valid, one cycle each
//   config   | cfg_wdata (table_length)                     | cfg_we, no wait
//
// a load transaction keeps busy low, so loads can come every cycle
// a search transaction probes the table once per cycle through the single memory port;
//   busy is high while the probes run and the result strobe is registered after the last
//   probe; the number of probes is at most floor(log2(length))+1, eleven for 1024 entries
// an empty table gives the not-found result the cycle after the transaction, busy low
// reset clears the controller, the length register and the result strobe; the table
//   itself is not cleared, so entries must be loaded before a search reaches them
// the result receiver cannot stall: each result is on the ports for one cycle only
`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input transaction
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [stbs_pkg::IDX_W-1:0]        in_load_index,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_load_value,
  input  logic signed [stbs_pkg::KEY_W-1:0] in_search_key,
  // result transaction
  output logic                              out_valid,
  output logic                              out_found,
  output logic [stbs_pkg::IDX_W-1:0]        out_found_index,
  // table length register
  input  logic                              cfg_we,
  input  logic [stbs_pkg::LEN_W-1:0]        cfg_wdata
);

  // commands from the state machine, status back from the datapath
  stbs_pkg::cmd_t cmd;
  stbs_pkg::sts_t sts;

  // state machine: idle takes loads and starts searches, search runs the probes
  stbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy)
  );

  // datapath: table memory with registered read, bounds, midpoint, compare
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_load_index   (in_load_index),
    .in_load_value   (in_load_value),
    .in_search_key   (in_search_key),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_found_index (out_found_index)
  );

  // a load never produces a result
  `STBS_ASSERT_NEXT(a_load_no_result, clk, rst_n, start && !busy && (in_req_type == stbs_pkg::REQ_LOAD), !out_valid)
  // a miss always reports index zero
  `STBS_ASSERT_IMPLY(a_miss_index_zero, clk, rst_n, out_valid && !out_found, out_found_index == '0)
  // a matching probe during a search is reported as found next cycle
  `STBS_ASSERT_NEXT(a_hit_reported, clk, rst_n, busy && sts.hit, out_valid && out_found)
  // a found result can only come out of a running search
  `STBS_ASSERT_IMPLY(a_hit_only_busy, clk, rst_n, cmd.finish_hit, busy)

endmodule
